>>> hdl/qwap_pkg.sv
package qwap_pkg;

  localparam int MAX_HEIGHT_DEF = 64;
  localparam int MAX_WIDTH_DEF  = 64;
  localparam int MAX_KERNEL_DEF = 16;

  localparam int PIX_W      = 8;
  localparam int POS_W      = 6;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;
  localparam int COORD_W    = 12;
  localparam int MULT_W     = 32;
  localparam int FRAC_BITS  = 24;
  localparam int ROUND_HALF = 8388608;
  localparam int ROUND_NEG  = 25165823;
  localparam int POOL_MIN   = -128;
  localparam int POOL_MAX   = 127;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_POOL = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_H    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_W    = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDES     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PADDINGS    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_POINTS = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_REQUANT     = 4'd7;

  localparam logic [6:0]  IN_HEIGHT_RST   = 7'd1;
  localparam logic [6:0]  IN_WIDTH_RST    = 7'd1;
  localparam logic [4:0]  KERNEL_H_RST    = 5'd1;
  localparam logic [4:0]  KERNEL_W_RST    = 5'd1;
  localparam logic [7:0]  STRIDES_RST     = 8'd17;
  localparam logic [7:0]  PADDINGS_RST    = 8'd0;
  localparam logic [15:0] ZERO_POINTS_RST = 16'd0;
  localparam logic [31:0] REQUANT_RST     = 32'd16777216;

  typedef struct packed {
    logic load_wr;
    logic start;
    logic step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
  } status_t;

endpackage

>>> hdl/qwap_in_if.sv
interface qwap_in_if;
  logic                               valid;
  logic                               ready;
  logic                               kind;
  logic signed [qwap_pkg::PIX_W-1:0]  pixel;
  logic        [qwap_pkg::POS_W-1:0]  out_row;
  logic        [qwap_pkg::POS_W-1:0]  out_col;

  modport source (output valid, kind, pixel, out_row, out_col, input ready);
  modport sink   (input valid, kind, pixel, out_row, out_col, output ready);
endinterface

>>> hdl/qwap_out_if.sv
interface qwap_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [qwap_pkg::PIX_W-1:0] pooled;

  modport source (output valid, pooled, input ready);
  modport sink   (input valid, pooled, output ready);
endinterface

>>> hdl/qwap_cfg_if.sv
interface qwap_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [qwap_pkg::CFG_IDX_W-1:0]      index;
  logic [qwap_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hdl/quantized_window_average_pool_core.sv
// channel  | dir | handshake     | payload
// in_ch    | in  | valid / ready | kind, pixel, out_row, out_col
// out_ch   | out | valid / ready | pooled
// cfg_ch   | in  | valid / ready | index, data (ready always high)
//
// A load request writes one pixel to the plane and produces no result.
// A pool request makes one plane read per window position through the single
// read port, then multiplies, rounds and clamps.
// Reset (rst_n low, synchronous) restores register defaults and the load position.
// A finished result waits in the output register; new requests are taken meanwhile,
// and a pool request stalls in its last step only while that register is still full.
module quantized_window_average_pool_core #(
  parameter int MAX_HEIGHT = qwap_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_WIDTH  = qwap_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = qwap_pkg::MAX_KERNEL_DEF
) (
  input logic        clk,
  input logic        rst_n,
  qwap_in_if.sink    in_ch,
  qwap_out_if.source out_ch,
  qwap_cfg_if.sink   cfg_ch
);

  qwap_pkg::cmd_t    cmd;
  qwap_pkg::status_t status;
  logic              in_ready;
  logic              out_valid;

  qwap_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.kind),
    .out_ready (out_ch.ready),
    .status    (status),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  qwap_dp #(
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .in_pixel  (in_ch.pixel),
    .in_row    (in_ch.out_row),
    .in_col    (in_ch.out_col),
    .cmd       (cmd),
    .status    (status),
    .pooled    (out_ch.pooled)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign cfg_ch.ready = 1'b1;

endmodule

>>> hdl/qwap_ram.sv
module qwap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/qwap_ctrl.sv
module qwap_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  input  logic              out_ready,
  input  qwap_pkg::status_t status,
  output logic              in_ready,
  output logic              out_valid,
  output qwap_pkg::cmd_t    cmd
);

  typedef enum logic [2:0] {
    IDLE,
    SCAN,
    DRAIN,
    MUL,
    RND,
    SAT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_acc;
  logic   out_free;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = (state_r == IDLE);
    in_acc    = in_valid && in_ready;
    out_free  = !out_valid_r || out_ready;
    unique case (state_r)
      IDLE: begin
        if (in_acc) begin
          if (in_kind == qwap_pkg::KIND_POOL) begin
            cmd.start = 1'b1;
            state_nxt = SCAN;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      SCAN: begin
        cmd.step = 1'b1;
        if (status.scan_last) begin
          state_nxt = DRAIN;
        end
      end
      DRAIN: state_nxt = MUL;
      MUL:   state_nxt = RND;
      RND:   state_nxt = SAT;
      SAT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = IDLE;
        end
      end
      default: state_nxt = IDLE;
    endcase
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> hdl/qwap_dp.sv
module qwap_dp #(
  parameter int MAX_HEIGHT = qwap_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_WIDTH  = qwap_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = qwap_pkg::MAX_KERNEL_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [qwap_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [qwap_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [qwap_pkg::PIX_W-1:0]     in_pixel,
  input  logic [qwap_pkg::POS_W-1:0]            in_row,
  input  logic [qwap_pkg::POS_W-1:0]            in_col,
  input  qwap_pkg::cmd_t                        cmd,
  output qwap_pkg::status_t                     status,
  output logic signed [qwap_pkg::PIX_W-1:0]     pooled
);

  localparam int DEPTH  = MAX_HEIGHT * MAX_WIDTH;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AREA_W = $clog2(DEPTH + 1);
  localparam int HW     = $clog2(MAX_HEIGHT + 1);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int KW     = $clog2(MAX_KERNEL + 1);
  localparam int CW     = qwap_pkg::COORD_W;
  localparam int PW     = CW - 1 + WW;
  localparam int DW     = qwap_pkg::PIX_W + 1;
  localparam int SW     = DW + 2 * KW;
  localparam int PRW    = SW + qwap_pkg::MULT_W + 1;
  localparam int QW     = PRW + 1 - qwap_pkg::FRAC_BITS;

  localparam logic signed [PRW-1:0] NEG_HALF = PRW'(-longint'(qwap_pkg::ROUND_HALF));
  localparam logic signed [PRW:0]   BIAS_POS = (PRW+1)'(longint'(qwap_pkg::ROUND_HALF));
  localparam logic signed [PRW:0]   BIAS_NEG = (PRW+1)'(longint'(qwap_pkg::ROUND_NEG));
  localparam logic signed [QW:0]    Y_MIN    = (QW+1)'(qwap_pkg::POOL_MIN);
  localparam logic signed [QW:0]    Y_MAX    = (QW+1)'(qwap_pkg::POOL_MAX);

  logic [6:0]  in_height_r;
  logic [6:0]  in_width_r;
  logic [4:0]  kernel_h_r;
  logic [4:0]  kernel_w_r;
  logic [7:0]  strides_r;
  logic [7:0]  paddings_r;
  logic [15:0] zero_points_r;
  logic [31:0] requant_r;

  logic [HW-1:0]     h_eff;
  logic [WW-1:0]     w_eff;
  logic [KW-1:0]     kh_eff;
  logic [KW-1:0]     kw_eff;
  logic [AREA_W-1:0] area;

  logic [AW-1:0]     wp_r, wp_nxt;
  logic [AW-1:0]     wr_pos;
  logic [AREA_W-1:0] wr_inc;

  logic signed [CW-1:0] r0_r, c0_r;
  logic signed [CW-1:0] r0_nxt, c0_nxt;
  logic [KW-1:0]        ki_r, kj_r;
  logic signed [CW-1:0] win_r, win_c;
  logic                 inb;
  logic [PW-1:0]        addr_full;
  logic [AW-1:0]        raddr;
  logic [qwap_pkg::PIX_W-1:0] rdata;
  logic                 acc_en_r;

  logic signed [DW-1:0]  diff;
  logic signed [SW-1:0]  acc_r;
  logic signed [PRW-1:0] prod_r;
  logic signed [PRW:0]   t_wide;
  logic signed [QW-1:0]  q_r;
  logic signed [QW:0]    y;
  logic signed [qwap_pkg::PIX_W-1:0] pooled_r, pooled_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_height_r   <= qwap_pkg::IN_HEIGHT_RST;
      in_width_r    <= qwap_pkg::IN_WIDTH_RST;
      kernel_h_r    <= qwap_pkg::KERNEL_H_RST;
      kernel_w_r    <= qwap_pkg::KERNEL_W_RST;
      strides_r     <= qwap_pkg::STRIDES_RST;
      paddings_r    <= qwap_pkg::PADDINGS_RST;
      zero_points_r <= qwap_pkg::ZERO_POINTS_RST;
      requant_r     <= qwap_pkg::REQUANT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qwap_pkg::REG_IN_HEIGHT:   in_height_r   <= cfg_data[6:0];
        qwap_pkg::REG_IN_WIDTH:    in_width_r    <= cfg_data[6:0];
        qwap_pkg::REG_KERNEL_H:    kernel_h_r    <= cfg_data[4:0];
        qwap_pkg::REG_KERNEL_W:    kernel_w_r    <= cfg_data[4:0];
        qwap_pkg::REG_STRIDES:     strides_r     <= cfg_data[7:0];
        qwap_pkg::REG_PADDINGS:    paddings_r    <= cfg_data[7:0];
        qwap_pkg::REG_ZERO_POINTS: zero_points_r <= cfg_data[15:0];
        qwap_pkg::REG_REQUANT:     requant_r     <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    h_eff  = (in_height_r == '0) ? HW'(1) :
             (int'(in_height_r) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(in_height_r);
    w_eff  = (in_width_r == '0) ? WW'(1) :
             (int'(in_width_r) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(in_width_r);
    kh_eff = (kernel_h_r == '0) ? KW'(1) :
             (int'(kernel_h_r) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(kernel_h_r);
    kw_eff = (kernel_w_r == '0) ? KW'(1) :
             (int'(kernel_w_r) > MAX_KERNEL) ? KW'(MAX_KERNEL) : KW'(kernel_w_r);
    area   = AREA_W'(h_eff) * AREA_W'(w_eff);
  end

  // wrap the load position, also when it is stale after a plane resize
  always_comb begin
    wr_pos = (AREA_W'(wp_r) >= area) ? '0 : wp_r;
    wr_inc = AREA_W'(wr_pos) + AREA_W'(1);
    wp_nxt = (wr_inc >= area) ? '0 : AW'(wr_inc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
    end else if (cmd.load_wr) begin
      wp_r <= wp_nxt;
    end
  end

  always_comb begin
    r0_nxt = $signed(CW'(in_row) * CW'(strides_r[7:4])) - $signed(CW'(paddings_r[7:4]));
    c0_nxt = $signed(CW'(in_col) * CW'(strides_r[3:0])) - $signed(CW'(paddings_r[3:0]));
    status.scan_last = (ki_r == kh_eff - KW'(1)) && (kj_r == kw_eff - KW'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      r0_r <= r0_nxt;
      c0_r <= c0_nxt;
      ki_r <= '0;
      kj_r <= '0;
    end else if (cmd.step) begin
      if (kj_r == kw_eff - KW'(1)) begin
        kj_r <= '0;
        ki_r <= ki_r + KW'(1);
      end else begin
        kj_r <= kj_r + KW'(1);
      end
    end
  end

  always_comb begin
    win_r     = r0_r + $signed(CW'(ki_r));
    win_c     = c0_r + $signed(CW'(kj_r));
    inb       = !win_r[CW-1] && (win_r < $signed(CW'(h_eff))) &&
                !win_c[CW-1] && (win_c < $signed(CW'(w_eff)));
    addr_full = PW'(win_r[CW-2:0]) * PW'(w_eff) + PW'(win_c[CW-2:0]);
    raddr     = AW'(addr_full);
  end

  qwap_ram #(
    .WIDTH (qwap_pkg::PIX_W),
    .DEPTH (DEPTH)
  ) u_plane (
    .clk   (clk),
    .we    (cmd.load_wr),
    .waddr (wr_pos),
    .wdata (in_pixel),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_en_r <= 1'b0;
    end else begin
      acc_en_r <= cmd.step && inb;
    end
  end

  assign diff = $signed({rdata[qwap_pkg::PIX_W-1], rdata}) -
                $signed({zero_points_r[7], zero_points_r[7:0]});

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc_r <= '0;
    end else if (acc_en_r) begin
      acc_r <= acc_r + SW'(diff);
    end
  end

  // add half (a larger bias below minus half), then truncate toward minus infinity
  always_comb begin
    t_wide = $signed({prod_r[PRW-1], prod_r}) + ((prod_r < NEG_HALF) ? BIAS_NEG : BIAS_POS);
    y      = (QW+1)'(q_r) + (QW+1)'($signed(zero_points_r[15:8]));
    if (y < Y_MIN) begin
      pooled_nxt = qwap_pkg::PIX_W'(Y_MIN);
    end else if (y > Y_MAX) begin
      pooled_nxt = qwap_pkg::PIX_W'(Y_MAX);
    end else begin
      pooled_nxt = y[qwap_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= acc_r * $signed({1'b0, requant_r});
    q_r    <= $signed(t_wide[PRW:qwap_pkg::FRAC_BITS]);
    if (cmd.out_load) begin
      pooled_r <= pooled_nxt;
    end
  end

  assign pooled = pooled_r;

endmodule
